// ===== rtl/core/tlik_pkg.sv =====
package tlik_pkg;

  // datapath widths
  localparam int VW    = 34;   // cordic x / y lanes
  localparam int ANGW  = 25;   // angles in 1/32768 degree
  localparam int SQW   = 30;   // square root result
  localparam int RW    = 33;   // square root remainder
  localparam int SVW   = 60;   // square root radicand
  localparam int STEPS = 16;   // cordic steps
  localparam int SQ_STEPS = SQW;

  localparam logic signed [ANGW-1:0] ANG_QUARTER = 25'sd2949120;
  localparam logic signed [ANGW-1:0] ANG_HALF    = 25'sd5898240;
  localparam logic [29:0] KINV_Q30 = 30'd652032874;

  // configuration register indexes
  localparam logic [1:0] REG_LINK_LENGTH = 2'd0;
  localparam logic [1:0] REG_BASE_Y      = 2'd1;
  localparam logic [1:0] REG_BASE_Z      = 2'd2;

  localparam logic [14:0] LINK_LENGTH_RST = 15'd4915;
  localparam logic signed [15:0] BASE_Y_RST = -16'sd4096;
  localparam logic signed [15:0] BASE_Z_RST = 16'sd7373;

  typedef struct packed {
    logic [RW-1:0]  rem;
    logic [SQW-1:0] root;
    logic [SVW-1:0] rad;
  } sq_t;

  typedef struct packed {
    logic signed [VW-1:0]   x;
    logic signed [VW-1:0]   y;
    logic signed [ANGW-1:0] z;
  } vec_t;

  typedef struct packed {
    logic signed [VW-1:0]   x;
    logic signed [VW-1:0]   y;
    logic signed [ANGW-1:0] ang;
  } rot_t;

  typedef struct packed {
    logic                   valid;
    logic                   dy_neg;
    logic                   dz_neg;
    logic                   unreach;
    logic [16:0]            ady;
    logic [16:0]            adz;
    logic                   dir_y0;
    logic                   dir_x0;
    logic                   half_y0;
    logic                   half_x0;
    logic                   flip;
    logic signed [ANGW-1:0] shoulder;
    logic signed [ANGW-1:0] elbow;
  } ctl_t;

  function automatic logic signed [ANGW-1:0] step_angle(input logic [3:0] idx);
    logic signed [ANGW-1:0] a;
    case (idx)
      4'd0:  a = 25'sd1474560;
      4'd1:  a = 25'sd870484;
      4'd2:  a = 25'sd459940;
      4'd3:  a = 25'sd233473;
      4'd4:  a = 25'sd117189;
      4'd5:  a = 25'sd58652;
      4'd6:  a = 25'sd29333;
      4'd7:  a = 25'sd14667;
      4'd8:  a = 25'sd7334;
      4'd9:  a = 25'sd3667;
      4'd10: a = 25'sd1833;
      4'd11: a = 25'sd917;
      4'd12: a = 25'sd458;
      4'd13: a = 25'sd229;
      4'd14: a = 25'sd115;
      4'd15: a = 25'sd57;
      default: a = '0;
    endcase
    return a;
  endfunction

  // arithmetic shift that truncates toward zero
  function automatic logic signed [VW-1:0] shr_trunc(input logic signed [VW-1:0] v,
                                                     input int s);
    logic signed [VW-1:0] m;
    m = -v;
    return v[VW-1] ? -(m >>> s) : (v >>> s);
  endfunction

  // shift with round half away from zero
  function automatic logic signed [VW-1:0] rnd_shr(input logic signed [VW-1:0] v,
                                                   input int s);
    logic signed [VW-1:0] mag;
    logic signed [VW-1:0] half;
    logic signed [VW-1:0] r;
    mag  = v[VW-1] ? -v : v;
    half = {{(VW-1){1'b0}}, 1'b1} <<< (s - 1);
    r    = (mag + half) >>> s;
    return v[VW-1] ? -r : r;
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [VW-1:0] v);
    logic signed [15:0] r;
    if (v > 34'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -34'sd32768) begin
      r = 16'sh8000;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/tlik_sqrt_cell.sv =====
module tlik_sqrt_cell (
  input  logic             clk,
  input  logic             en,
  input  tlik_pkg::sq_t    sq_i,
  output tlik_pkg::sq_t    sq_o
);

  tlik_pkg::sq_t sq_r, sq_nxt;
  logic [tlik_pkg::RW-1:0] rem_sh;
  logic [tlik_pkg::RW-1:0] trial;

  // one result bit per cell, two radicand bits consumed
  always_comb begin
    rem_sh = {sq_i.rem[tlik_pkg::RW-3:0], sq_i.rad[tlik_pkg::SVW-1 -: 2]};
    trial  = {1'b0, sq_i.root, 2'b01};
    sq_nxt.rad = {sq_i.rad[tlik_pkg::SVW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      sq_nxt.rem  = rem_sh - trial;
      sq_nxt.root = {sq_i.root[tlik_pkg::SQW-2:0], 1'b1};
    end else begin
      sq_nxt.rem  = rem_sh;
      sq_nxt.root = {sq_i.root[tlik_pkg::SQW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_r <= sq_nxt;
    end
  end

  assign sq_o = sq_r;

endmodule

// ===== rtl/core/tlik_vec_cell.sv =====
module tlik_vec_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           en,
  input  tlik_pkg::vec_t vec_i,
  output tlik_pkg::vec_t vec_o
);

  tlik_pkg::vec_t vec_r, vec_nxt;
  logic signed [tlik_pkg::VW-1:0]   ddx, ddy;
  logic signed [tlik_pkg::ANGW-1:0] ang;

  always_comb begin
    ddx = tlik_pkg::shr_trunc(vec_i.y, STEP);
    ddy = tlik_pkg::shr_trunc(vec_i.x, STEP);
    ang = tlik_pkg::step_angle(4'(STEP));
    if (vec_i.y > 0) begin
      vec_nxt.x = vec_i.x + ddx;
      vec_nxt.y = vec_i.y - ddy;
      vec_nxt.z = vec_i.z + ang;
    end else begin
      vec_nxt.x = vec_i.x - ddx;
      vec_nxt.y = vec_i.y + ddy;
      vec_nxt.z = vec_i.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vec_r <= vec_nxt;
    end
  end

  assign vec_o = vec_r;

endmodule

// ===== rtl/core/tlik_rot_cell.sv =====
module tlik_rot_cell #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           en,
  input  tlik_pkg::rot_t rot_i,
  output tlik_pkg::rot_t rot_o
);

  tlik_pkg::rot_t rot_r, rot_nxt;
  logic signed [tlik_pkg::VW-1:0]   ddx, ddy;
  logic signed [tlik_pkg::ANGW-1:0] ang;

  always_comb begin
    ddx = tlik_pkg::shr_trunc(rot_i.y, STEP);
    ddy = tlik_pkg::shr_trunc(rot_i.x, STEP);
    ang = tlik_pkg::step_angle(4'(STEP));
    if (rot_i.ang >= 0) begin
      rot_nxt.x   = rot_i.x - ddx;
      rot_nxt.y   = rot_i.y + ddy;
      rot_nxt.ang = rot_i.ang - ang;
    end else begin
      rot_nxt.x   = rot_i.x + ddx;
      rot_nxt.y   = rot_i.y - ddy;
      rot_nxt.ang = rot_i.ang + ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
    end
  end

  assign rot_o = rot_r;

endmodule

// ===== rtl/core/two_link_planar_ik_solver_core.sv =====
// two-link planar inverse kinematics, one target point in, one joint solution out.
// in_* channel: one beat per target (y, z) in Q4.12.
// out_* channel: shoulder and elbow angle in 1/128 degree, elbow joint position
// in Q4.12, and the unreachable flag on out_tuser.
// cfg_* channel: register writes (link length, base y, base z), always ready;
// write only while no target is in flight.
// the datapath is a row of cells: 3 setup stages, 30 square root cells (one root
// bit each), a cordic load stage, 16 vectoring cordic cells, an angle stage,
// 16 rotation cordic cells and the output register.
// unless the row holds: one target per cycle, and every cell passes its data on.
// when out_tready is low with a result waiting, the whole row holds and
// in_tready drops in the same cycle; it rises again as soon as the result is taken.
// reset clears all valid flags and loads the default registers
// (link 4915, base y -4096, base z 7373); results in flight are dropped.
module two_link_planar_ik_solver_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // target_y, target_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // shoulder_angle, elbow_angle, elbow_y, elbow_z
  output logic        out_tuser,  // unreachable
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int VW    = tlik_pkg::VW;
  localparam int ANGW  = tlik_pkg::ANGW;
  localparam int STEPS = tlik_pkg::STEPS;
  localparam int SQN   = tlik_pkg::SQ_STEPS;

  logic                    en;
  logic [14:0]             link_length_r;
  logic signed [15:0]      base_y_r, base_z_r;

  // configuration
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_length_r <= tlik_pkg::LINK_LENGTH_RST;
      base_y_r      <= tlik_pkg::BASE_Y_RST;
      base_z_r      <= tlik_pkg::BASE_Z_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        tlik_pkg::REG_LINK_LENGTH: link_length_r <= cfg_data[14:0];
        tlik_pkg::REG_BASE_Y:      base_y_r      <= cfg_data;
        tlik_pkg::REG_BASE_Z:      base_z_r      <= cfg_data;
        default: ;
      endcase
    end
  end

  logic out_valid_r;
  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // stage 1: offsets from the base
  logic signed [16:0] dy, dz;
  tlik_pkg::ctl_t ctl1_nxt, ctl1_r, ctl2_r, ctl3_nxt;
  always_comb begin
    dy = {in_tdata[15], in_tdata[15:0]} - {base_y_r[15], base_y_r};
    dz = {base_z_r[15], base_z_r} - {in_tdata[31], in_tdata[31:16]};
    ctl1_nxt        = '0;
    ctl1_nxt.valid  = in_tvalid;
    ctl1_nxt.dy_neg = dy[16];
    ctl1_nxt.dz_neg = dz[16];
    ctl1_nxt.ady    = dy[16] ? 17'(-dy) : 17'(dy);
    ctl1_nxt.adz    = dz[16] ? 17'(-dz) : 17'(dz);
  end

  // stage 2: squares
  logic [33:0] ady2_r, adz2_r;
  logic [29:0] l2_r;

  // stage 3: distance compare, radicands
  logic [34:0] rsq;
  logic [31:0] four_l2;
  logic [31:0] hsq;
  tlik_pkg::sq_t sq_r_init, sq_h_init;
  tlik_pkg::sq_t sq_r_chain [0:SQN];
  tlik_pkg::sq_t sq_h_chain [0:SQN];
  tlik_pkg::ctl_t ctl_sq_r [0:SQN];

  always_comb begin
    rsq      = {1'b0, ady2_r} + {1'b0, adz2_r};
    four_l2  = {l2_r, 2'b00};
    hsq      = four_l2 - rsq[31:0];
    ctl3_nxt = ctl2_r;
    ctl3_nxt.unreach = rsq > {3'b000, four_l2};
    sq_r_init = '{rem: '0, root: '0, rad: {rsq[31:0], 28'd0}};
    sq_h_init = '{rem: '0, root: '0, rad: {hsq, 28'd0}};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl1_r      <= '0;
      ctl2_r      <= '0;
      ctl_sq_r[0] <= '0;
    end else if (en) begin
      ctl1_r      <= ctl1_nxt;
      ctl2_r      <= ctl1_r;
      ctl_sq_r[0] <= ctl3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ady2_r        <= 34'(ctl1_r.ady) * 34'(ctl1_r.ady);
      adz2_r        <= 34'(ctl1_r.adz) * 34'(ctl1_r.adz);
      l2_r          <= 30'(link_length_r) * 30'(link_length_r);
      sq_r_chain[0] <= sq_r_init;
      sq_h_chain[0] <= sq_h_init;
    end
  end

  // square root cells for r and h
  genvar k;
  generate
    for (k = 0; k < SQN; k++) begin : g_sq
      tlik_sqrt_cell u_sq_r (.clk(clk), .en(en), .sq_i(sq_r_chain[k]), .sq_o(sq_r_chain[k+1]));
      tlik_sqrt_cell u_sq_h (.clk(clk), .en(en), .sq_i(sq_h_chain[k]), .sq_o(sq_h_chain[k+1]));
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ctl_sq_r[k+1] <= '0;
        end else if (en) begin
          ctl_sq_r[k+1] <= ctl_sq_r[k];
        end
      end
    end
  endgenerate

  // vectoring cordic: direction lane and half-elbow lane
  tlik_pkg::vec_t vd_chain [0:STEPS];
  tlik_pkg::vec_t vh_chain [0:STEPS];
  tlik_pkg::ctl_t ctl_vec_r [0:STEPS];
  tlik_pkg::ctl_t ctlv_nxt;
  logic [tlik_pkg::SQW-1:0] r_root, h_root;

  always_comb begin
    r_root   = sq_r_chain[SQN].root;
    h_root   = sq_h_chain[SQN].root;
    ctlv_nxt = ctl_sq_r[SQN];
    ctlv_nxt.dir_y0  = ctl_sq_r[SQN].ady == '0;
    ctlv_nxt.dir_x0  = ctl_sq_r[SQN].adz == '0;
    ctlv_nxt.half_y0 = h_root == '0;
    ctlv_nxt.half_x0 = r_root == '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vd_chain[0] <= '{x: {3'd0, ctl_sq_r[SQN].adz, 14'd0},
                       y: {3'd0, ctl_sq_r[SQN].ady, 14'd0}, z: '0};
      vh_chain[0] <= '{x: {4'd0, r_root}, y: {4'd0, h_root}, z: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_vec_r[0] <= '0;
    end else if (en) begin
      ctl_vec_r[0] <= ctlv_nxt;
    end
  end

  generate
    for (k = 0; k < STEPS; k++) begin : g_vec
      tlik_vec_cell #(.STEP(k)) u_vd (.clk(clk), .en(en), .vec_i(vd_chain[k]),
                                      .vec_o(vd_chain[k+1]));
      tlik_vec_cell #(.STEP(k)) u_vh (.clk(clk), .en(en), .vec_i(vh_chain[k]),
                                      .vec_o(vh_chain[k+1]));
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ctl_vec_r[k+1] <= '0;
        end else if (en) begin
          ctl_vec_r[k+1] <= ctl_vec_r[k];
        end
      end
    end
  endgenerate

  // angle stage: joint angles and fold for the rotation cordic
  function automatic logic signed [ANGW-1:0] clamp_ang(input logic signed [ANGW-1:0] z);
    logic signed [ANGW-1:0] r;
    if (z < 0) begin
      r = '0;
    end else if (z > tlik_pkg::ANG_QUARTER) begin
      r = tlik_pkg::ANG_QUARTER;
    end else begin
      r = z;
    end
    return r;
  endfunction

  tlik_pkg::ctl_t cv;
  tlik_pkg::ctl_t ctlr_nxt;
  logic signed [ANGW-1:0] dir_raw, dir, half, sh, el, ang0;
  logic [44:0] kx_prod;
  tlik_pkg::rot_t rot_init;
  tlik_pkg::rot_t rot_chain [0:STEPS];
  tlik_pkg::ctl_t ctl_rot_r [0:STEPS];

  always_comb begin
    cv = ctl_vec_r[STEPS];
    if (cv.dir_y0) begin
      dir_raw = '0;
    end else if (cv.dir_x0) begin
      dir_raw = tlik_pkg::ANG_QUARTER;
    end else begin
      dir_raw = clamp_ang(vd_chain[STEPS].z);
    end
    dir = cv.dz_neg ? tlik_pkg::ANG_HALF - dir_raw : dir_raw;
    if (cv.half_y0) begin
      half = '0;
    end else if (cv.half_x0) begin
      half = tlik_pkg::ANG_QUARTER;
    end else begin
      half = clamp_ang(vh_chain[STEPS].z);
    end
    if (cv.unreach) begin
      sh = dir;
      el = '0;
    end else begin
      sh = dir - half;
      el = half <<< 1;
    end
    if (cv.dy_neg) begin
      sh = -sh;
      el = -el;
    end
    ctlr_nxt = cv;
    ctlr_nxt.shoulder = sh;
    ctlr_nxt.elbow    = el;
    if (sh > tlik_pkg::ANG_QUARTER) begin
      ang0 = sh - tlik_pkg::ANG_HALF;
      ctlr_nxt.flip = 1'b1;
    end else if (sh < -tlik_pkg::ANG_QUARTER) begin
      ang0 = sh + tlik_pkg::ANG_HALF;
      ctlr_nxt.flip = 1'b1;
    end else begin
      ang0 = sh;
      ctlr_nxt.flip = 1'b0;
    end
    kx_prod  = 45'(link_length_r) * 45'(tlik_pkg::KINV_Q30);
    rot_init = '{x: {3'd0, kx_prod[44:14]}, y: '0, ang: ang0};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_chain[0] <= rot_init;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_rot_r[0] <= '0;
    end else if (en) begin
      ctl_rot_r[0] <= ctlr_nxt;
    end
  end

  generate
    for (k = 0; k < STEPS; k++) begin : g_rot
      tlik_rot_cell #(.STEP(k)) u_rot (.clk(clk), .en(en), .rot_i(rot_chain[k]),
                                       .rot_o(rot_chain[k+1]));
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          ctl_rot_r[k+1] <= '0;
        end else if (en) begin
          ctl_rot_r[k+1] <= ctl_rot_r[k];
        end
      end
    end
  endgenerate

  // output stage
  tlik_pkg::ctl_t co;
  logic signed [VW-1:0] cx, sy, rc, rs, ey, ez, sh_r, el_r;
  logic [63:0] out_data_nxt;
  logic [63:0] out_data_r;
  logic        out_user_r;

  always_comb begin
    co   = ctl_rot_r[STEPS];
    cx   = co.flip ? -rot_chain[STEPS].x : rot_chain[STEPS].x;
    sy   = co.flip ? -rot_chain[STEPS].y : rot_chain[STEPS].y;
    rc   = tlik_pkg::rnd_shr(cx, 16);
    rs   = tlik_pkg::rnd_shr(sy, 16);
    ey   = VW'(base_y_r) + rs;
    ez   = VW'(base_z_r) - rc;
    sh_r = tlik_pkg::rnd_shr(VW'(co.shoulder), 8);
    el_r = tlik_pkg::rnd_shr(VW'(co.elbow), 8);
    out_data_nxt = {tlik_pkg::sat16(ez), tlik_pkg::sat16(ey), el_r[15:0], sh_r[15:0]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= co.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
      out_user_r <= co.unreach;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

endmodule

// ===== tb/sv/tb_two_link_planar_ik_solver_core.sv =====
`timescale 1ns / 1ps

module tb_two_link_planar_ik_solver_core;

  localparam longint QUARTER_TURN = 2949120;
  localparam longint HALF_TURN    = 5898240;
  localparam longint KINV         = 652032874;
  localparam int     IDLE_LIMIT   = 5000;
  localparam int     HOLD_CYCLES  = 250;
  localparam logic [1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [15:0] shoulder;
    logic signed [15:0] elbow;
    logic signed [15:0] elbow_y;
    logic signed [15:0] elbow_z;
    logic               unreach;
  } ik_sol_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // target_y, target_z
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // shoulder_angle, elbow_angle, elbow_y, elbow_z
  logic        out_tuser;       // unreachable
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  two_link_planar_ik_solver_core i_dut (.*);

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // geometry as the solver sees it
  longint link_len = 4915;
  longint base_y_pos = -4096;
  longint base_z_pos = 7373;

  ik_sol_t solutions_due[$];
  int      error_count = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      hold_requests = 0;
  int      hold_served = 0;
  int      hold_left = 0;
  int      idle_cycles = 0;

  function automatic longint trunc_shr(longint v, int s);
    return v >= 0 ? (v >>> s) : -((-v) >>> s);
  endfunction

  function automatic longint round_away(longint v, int s);
    longint half_lsb;
    half_lsb = longint'(1) << (s - 1);
    return v >= 0 ? ((v + half_lsb) >>> s) : -(((-v) + half_lsb) >>> s);
  endfunction

  function automatic longint clip16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  function automatic longint isqrt(longint unsigned v);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic longint atan_vec(longint yv, longint xv);
    longint x, y, z, dx, dyy;
    x = xv;
    y = yv;
    z = 0;
    if (yv == 0) return 0;
    if (xv == 0) return QUARTER_TURN;
    for (int i = 0; i < 16; i++) begin
      dx = trunc_shr(y, i);
      dyy = trunc_shr(x, i);
      if (y > 0) begin
        x += dx; y -= dyy; z += longint'(tlik_pkg::step_angle(i[3:0]));
      end else begin
        x -= dx; y += dyy; z -= longint'(tlik_pkg::step_angle(i[3:0]));
      end
    end
    if (z < 0) z = 0;
    if (z > QUARTER_TURN) z = QUARTER_TURN;
    return z;
  endfunction

  function automatic void rotate_link(longint ang, longint len, output longint c,
                                      output longint s);
    bit     flip;
    longint x, y, dx, dyy;
    flip = 0;
    y = 0;
    if (ang > QUARTER_TURN) begin
      ang -= HALF_TURN; flip = 1;
    end else if (ang < -QUARTER_TURN) begin
      ang += HALF_TURN; flip = 1;
    end
    x = (len * KINV) >>> 14;
    for (int i = 0; i < 16; i++) begin
      dx = trunc_shr(y, i);
      dyy = trunc_shr(x, i);
      if (ang >= 0) begin
        x -= dx; y += dyy; ang -= longint'(tlik_pkg::step_angle(i[3:0]));
      end else begin
        x += dx; y -= dyy; ang += longint'(tlik_pkg::step_angle(i[3:0]));
      end
    end
    c = flip ? -x : x;
    s = flip ? -y : y;
  endfunction

  function automatic ik_sol_t solve_joints(logic signed [15:0] ty, logic signed [15:0] tz);
    ik_sol_t sol;
    longint  dy, dz, ady, adz, dir, half_ang, shoulder, elbow, c, s, r, h;
    longint unsigned rsq, four_l2;
    bit      unreach;
    dy = longint'(ty) - base_y_pos;
    dz = base_z_pos - longint'(tz);
    ady = dy < 0 ? -dy : dy;
    adz = dz < 0 ? -dz : dz;
    rsq = ady * ady + adz * adz;
    four_l2 = 4 * link_len * link_len;
    unreach = rsq > four_l2;
    dir = atan_vec(ady * 16384, adz * 16384);
    if (dz < 0) dir = HALF_TURN - dir;
    if (unreach) begin
      shoulder = dir;
      elbow = 0;
    end else begin
      r = isqrt(rsq << 28);
      h = isqrt((four_l2 - rsq) << 28);
      half_ang = atan_vec(h, r);
      shoulder = dir - half_ang;
      elbow = 2 * half_ang;
    end
    if (dy < 0) begin
      shoulder = -shoulder;
      elbow = -elbow;
    end
    rotate_link(shoulder, link_len, c, s);
    sol.shoulder = 16'(round_away(shoulder, 8));
    sol.elbow = 16'(round_away(elbow, 8));
    sol.elbow_y = 16'(clip16(base_y_pos + round_away(s, 16)));
    sol.elbow_z = 16'(clip16(base_z_pos - round_away(c, 16)));
    sol.unreach = unreach;
    return sol;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    ik_sol_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (solutions_due.size() == 0) begin
        report_mismatch("unexpected beat", 1, 0);
      end else begin
        want = solutions_due.pop_front();
        if (out_tdata[15:0] !== want.shoulder)
          report_mismatch("shoulder_angle", $signed(out_tdata[15:0]), want.shoulder);
        if (out_tdata[31:16] !== want.elbow)
          report_mismatch("elbow_angle", $signed(out_tdata[31:16]), want.elbow);
        if (out_tdata[47:32] !== want.elbow_y)
          report_mismatch("elbow_y", $signed(out_tdata[47:32]), want.elbow_y);
        if (out_tdata[63:48] !== want.elbow_z)
          report_mismatch("elbow_z", $signed(out_tdata[63:48]), want.elbow_z);
        if (out_tuser !== want.unreach)
          report_mismatch("unreachable", out_tuser, want.unreach);
      end
    end
  end

  // receiver: random stalls plus long hold-offs on request
  always @(negedge clk) begin
    if (hold_requests != hold_served) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)
        || !rst_n) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_target(logic signed [15:0] ty, logic signed [15:0] tz);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {tz, ty};
    do @(posedge clk); while (!in_tready);
    solutions_due = {solutions_due, solve_joints(ty, tz)};
    @(negedge clk);
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    wait (solutions_due.size() == 0);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      tlik_pkg::REG_LINK_LENGTH: link_len = longint'(value[14:0]);
      tlik_pkg::REG_BASE_Y:      base_y_pos = longint'($signed(value));
      tlik_pkg::REG_BASE_Z:      base_z_pos = longint'($signed(value));
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_geometry(logic [15:0] len, logic [15:0] by, logic [15:0] bz);
    drain();
    write_reg(tlik_pkg::REG_LINK_LENGTH, len);
    write_reg(tlik_pkg::REG_BASE_Y, by);
    write_reg(tlik_pkg::REG_BASE_Z, bz);
  endtask

  // mostly targets around the base, up to a little beyond full reach, some anywhere
  task automatic send_random_target();
    longint span, ty, tz;
    span = 2 * link_len + link_len / 4 + 1;
    if (span > 65535) span = 65535;
    case ($urandom_range(0, 5))
      0: begin
        ty = $signed(16'($urandom));
        tz = $signed(16'($urandom));
      end
      1: begin
        ty = base_y_pos + $signed(8'($urandom));
        tz = base_z_pos + $signed(8'($urandom));
      end
      default: begin
        ty = base_y_pos + longint'($urandom_range(0, 2 * span)) - span;
        tz = base_z_pos + longint'($urandom_range(0, 2 * span)) - span;
      end
    endcase
    send_target(16'(clip16(ty)), 16'(clip16(tz)));
  endtask

  task automatic test_directed();
    longint by, bz;
    by = base_y_pos;
    bz = base_z_pos;
    send_target(16'(by), 16'(bz));                       // at the base
    send_target(16'(by), 16'(bz - 9830));                // exactly at full reach
    send_target(16'(by), 16'(bz - 9831));                // just beyond
    send_target(16'(by), 16'(bz + 9830));                // full reach, other side
    send_target(16'(by), 16'(bz + 100));                 // dy zero, dz negative
    send_target(16'(by + 2000), 16'(bz));                // dz zero
    send_target(16'(by - 2000), 16'(bz));                // below the base
    send_target(16'(by - 1500), 16'(bz - 1200));
    send_target(16'(by + 1500), 16'(bz + 1200));
    send_target(-16'sd32768, -16'sd32768);
    send_target(16'sd32767, 16'sd32767);
    send_target(16'sd32767, -16'sd32768);
    send_target(-16'sd32768, 16'sd32767);
    send_target(16'sd0, 16'sd0);
    drain();
    write_reg(REG_UNUSED, 16'hffff);           // ignored index
    send_target(16'(by + 300), 16'(bz - 300));
    // zero link length, with the ignored top bit set
    set_geometry(16'h8000, 16'sd0, 16'sd0);
    send_target(16'sd0, 16'sd0);
    send_target(16'sd1, 16'sd0);
    send_target(16'sd0, -16'sd1);
    set_geometry(16'd1, -16'sd32768, 16'sd32767);
    send_target(-16'sd32768, 16'sd32767);
    send_target(-16'sd32767, 16'sd32766);
    send_target(-16'sd32766, 16'sd32767);
    send_target(16'sd32767, -16'sd32768);
  endtask

  task automatic test_random_phase(int n_items);
    for (int b = 0; b < 5; b++) begin
      case (b)
        0: set_geometry(16'd32767, 16'sd32767, -16'sd32768);
        1: set_geometry(16'd1, 16'sd0, 16'sd0);
        2: set_geometry(16'(tlik_pkg::LINK_LENGTH_RST), tlik_pkg::BASE_Y_RST,
                        tlik_pkg::BASE_Z_RST);
        default: set_geometry(16'($urandom_range(1, 32767)), 16'($urandom), 16'($urandom));
      endcase
      for (int k = 0; k < n_items / 5; k++) send_random_target();
    end
  endtask

  task automatic test_backpressure();
    set_geometry(16'd6000, 16'sd1000, -16'sd2000);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    for (int k = 0; k < 150; k++) send_random_target();
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    send_idle_pct = 24;
    recv_idle_pct = 83;
    test_directed();
    test_random_phase(500);
    send_idle_pct = 83;
    recv_idle_pct = 24;
    test_random_phase(500);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_phase(500);
    test_backpressure();
    drain();
    repeat (80) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
